>>> sv/vgt_pkg.sv
// vgt_pkg: shared types and constants for the virtual generic timer register file.
// No dependencies.
package vgt_pkg;

    localparam int unsigned CNT_W  = 64;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] FREQ_RESET  = 32'd100000000;
    localparam logic [WORD_W-1:0] CTL_ENABLE  = 32'h0000_0001;
    localparam logic [WORD_W-1:0] CTL_IMASK   = 32'h0000_0002;
    localparam logic [WORD_W-1:0] CTL_ISTATUS = 32'h0000_0004;

    typedef enum logic [2:0] {
        MODE_RD32 = 3'd0,
        MODE_WR32 = 3'd1,
        MODE_RD64 = 3'd2,
        MODE_WR64 = 3'd3,
        MODE_TICK = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        SEL_FRQ   = 4'd0,
        SEL_KCTL  = 4'd1,
        SEL_PCTL  = 4'd2,
        SEL_VCTL  = 4'd3,
        SEL_PTVAL = 4'd4,
        SEL_VTVAL = 4'd5,
        SEL_PCT   = 4'd6,
        SEL_VCT   = 4'd7,
        SEL_PCVAL = 4'd8,
        SEL_VCVAL = 4'd9
    } sel_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [3:0]        reg_sel;
        logic [WORD_W-1:0] write_low;
        logic [WORD_W-1:0] write_high;
        logic [CNT_W-1:0]  sys_count;
        logic [CNT_W-1:0]  vcount;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_low;
        logic [WORD_W-1:0] read_high;
        logic              access_error;
        logic              irq_pulse;
    } result_t;

endpackage

>>> sv/vgt_in_stage.sv
// vgt_in_stage: input beat register; also registers the guest virtual count.
// Depends on vgt_pkg.
module vgt_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                mode,
    input  logic [3:0]                reg_sel,
    input  logic [vgt_pkg::WORD_W-1:0] write_low,
    input  logic [vgt_pkg::WORD_W-1:0] write_high,
    input  logic [vgt_pkg::CNT_W-1:0]  sys_count,
    input  logic [vgt_pkg::CNT_W-1:0]  counter_offset,
    output logic                      item_valid,
    output vgt_pkg::item_t            item,
    input  logic                      item_take
);

    logic           valid_reg;
    vgt_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.mode       <= mode;
            item_reg.reg_sel    <= reg_sel;
            item_reg.write_low  <= write_low;
            item_reg.write_high <= write_high;
            item_reg.sys_count  <= sys_count;
            item_reg.vcount     <= sys_count - counter_offset;
        end
    end

endmodule

>>> sv/vgt_core.sv
// vgt_core: timer register state, access decode and physical timer expiry.
// Depends on vgt_pkg.
module vgt_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_fire,
    input  vgt_pkg::item_t            item,
    input  logic [vgt_pkg::CNT_W-1:0]  counter_offset,
    output vgt_pkg::result_t          result
);

    logic [vgt_pkg::WORD_W-1:0] freq_reg, freq_next;
    logic [vgt_pkg::WORD_W-1:0] kctl_reg, kctl_next;
    logic [vgt_pkg::WORD_W-1:0] pctl_reg, pctl_next;
    logic [vgt_pkg::WORD_W-1:0] vctl_reg, vctl_next;
    logic [vgt_pkg::CNT_W-1:0]  pcmp_reg, pcmp_next;
    logic [vgt_pkg::CNT_W-1:0]  vcmp_reg, vcmp_next;
    logic                       armed_reg, armed_next;

    logic [vgt_pkg::CNT_W-1:0]  rd;
    logic                       err;
    logic                       irq;
    logic                       is_rd;
    logic [vgt_pkg::CNT_W-1:0]  tval_cmp;
    logic [vgt_pkg::CNT_W-1:0]  tval_rd;
    logic [vgt_pkg::CNT_W-1:0]  tval_wr;
    logic [vgt_pkg::CNT_W-1:0]  deadline;
    logic [vgt_pkg::CNT_W-1:0]  wr64;

    assign is_rd    = (item.mode == vgt_pkg::MODE_RD32) || (item.mode == vgt_pkg::MODE_RD64);
    assign tval_cmp = (item.reg_sel == vgt_pkg::SEL_PTVAL) ? pcmp_reg : vcmp_reg;
    assign tval_rd  = tval_cmp - item.vcount;
    assign tval_wr  = item.vcount + {{32{item.write_low[31]}}, item.write_low};
    assign deadline = pcmp_reg + counter_offset;
    assign wr64     = {item.write_high, item.write_low};

    always_comb begin
        freq_next  = freq_reg;
        kctl_next  = kctl_reg;
        pctl_next  = pctl_reg;
        vctl_next  = vctl_reg;
        pcmp_next  = pcmp_reg;
        vcmp_next  = vcmp_reg;
        armed_next = armed_reg;
        rd         = '0;
        err        = 1'b0;
        irq        = 1'b0;
        unique case (vgt_pkg::mode_t'(item.mode))
            vgt_pkg::MODE_RD32, vgt_pkg::MODE_WR32: begin
                unique case (vgt_pkg::sel_t'(item.reg_sel))
                    vgt_pkg::SEL_FRQ: begin
                        if (is_rd) rd = {32'd0, freq_reg};
                        else       freq_next = item.write_low;
                    end
                    vgt_pkg::SEL_KCTL: begin
                        if (is_rd) rd = {32'd0, kctl_reg};
                        else       kctl_next = item.write_low;
                    end
                    vgt_pkg::SEL_PCTL: begin
                        if (is_rd) rd = {32'd0, pctl_reg};
                        else       pctl_next = item.write_low;
                    end
                    vgt_pkg::SEL_VCTL: begin
                        if (is_rd) rd = {32'd0, vctl_reg};
                        else       vctl_next = item.write_low;
                    end
                    vgt_pkg::SEL_PTVAL: begin
                        if (is_rd) begin
                            rd = {32'd0, tval_rd[31:0]};
                        end else begin
                            pcmp_next  = tval_wr;
                            armed_next = 1'b1;
                        end
                    end
                    vgt_pkg::SEL_VTVAL: begin
                        if (is_rd) rd = {32'd0, tval_rd[31:0]};
                        else       vcmp_next = tval_wr;
                    end
                    default: err = 1'b1;
                endcase
            end
            vgt_pkg::MODE_RD64, vgt_pkg::MODE_WR64: begin
                unique case (vgt_pkg::sel_t'(item.reg_sel))
                    vgt_pkg::SEL_PCT, vgt_pkg::SEL_VCT: begin
                        if (is_rd) rd  = item.vcount;
                        else       err = 1'b1;
                    end
                    vgt_pkg::SEL_PCVAL: begin
                        if (is_rd) begin
                            rd = pcmp_reg;
                        end else begin
                            pcmp_next  = wr64;
                            armed_next = 1'b1;
                        end
                    end
                    vgt_pkg::SEL_VCVAL: begin
                        if (is_rd) rd = vcmp_reg;
                        else       vcmp_next = wr64;
                    end
                    default: err = 1'b1;
                endcase
            end
            vgt_pkg::MODE_TICK: begin
                if (armed_reg && (item.sys_count >= deadline)) begin
                    armed_next = 1'b0;
                    if ((pctl_reg & vgt_pkg::CTL_ENABLE) != '0) begin
                        pctl_next = pctl_reg | vgt_pkg::CTL_ISTATUS;
                        irq       = ((pctl_reg & vgt_pkg::CTL_IMASK) == '0);
                    end
                end
            end
            default: err = 1'b1;
        endcase
    end

    assign result.read_low     = rd[31:0];
    assign result.read_high    = rd[63:32];
    assign result.access_error = err;
    assign result.irq_pulse    = irq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg  <= vgt_pkg::FREQ_RESET;
            kctl_reg  <= '0;
            pctl_reg  <= vgt_pkg::CTL_IMASK;
            vctl_reg  <= vgt_pkg::CTL_IMASK;
            pcmp_reg  <= '0;
            vcmp_reg  <= '0;
            armed_reg <= 1'b0;
        end else if (item_fire) begin
            freq_reg  <= freq_next;
            kctl_reg  <= kctl_next;
            pctl_reg  <= pctl_next;
            vctl_reg  <= vctl_next;
            pcmp_reg  <= pcmp_next;
            vcmp_reg  <= vcmp_next;
            armed_reg <= armed_next;
        end
    end

endmodule

>>> sv/vgt_out_stage.sv
// vgt_out_stage: result beat register toward the master side.
// Depends on vgt_pkg.
module vgt_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  vgt_pkg::result_t res,
    output logic             res_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output vgt_pkg::result_t m_res
);

    logic             valid_reg;
    vgt_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/virtual_generic_timer_regs_unit.sv
// virtual_generic_timer_regs_unit: top level of the guest timer register file.
// Depends on vgt_pkg, vgt_in_stage, vgt_core, vgt_out_stage.
//
//  channel  | ports                     | contents
//  ---------+---------------------------+------------------------------------------
//  input    | s_axis_tvalid/tready/...  | one access or tick per beat
//  result   | m_axis_tvalid/tready/...  | one result beat per input beat, in order
//  config   | cfg_wr_en, cfg_wr_data    | counter_offset
//
// One beat per cycle unless m_axis_tready stalls; path: input register, result register.
// Register state updates as a beat moves from the input register to the result register.
// A stalled result register holds the input register, which then deasserts s_axis_tready.
// aresetn is synchronous, active low; counter_offset resets to zero.
module virtual_generic_timer_regs_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // reg_sel, write_low, write_high, sys_count, zero pad
    input  logic [2:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // read_low, read_high, access_error, irq_pulse, zero pad
);

    logic [vgt_pkg::CNT_W-1:0] offset_reg;
    logic                      item_valid;
    vgt_pkg::item_t            item;
    logic                      res_ready;
    logic                      item_fire;
    vgt_pkg::result_t          res;
    vgt_pkg::result_t          m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            offset_reg <= cfg_wr_data;
        end
    end

    assign item_fire = item_valid && res_ready;

    vgt_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_axis_tvalid),
        .s_ready        (s_axis_tready),
        .mode           (s_axis_tuser),
        .reg_sel        (s_axis_tdata[3:0]),
        .write_low      (s_axis_tdata[35:4]),
        .write_high     (s_axis_tdata[67:36]),
        .sys_count      (s_axis_tdata[131:68]),
        .counter_offset (offset_reg),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_fire)
    );

    vgt_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_fire      (item_fire),
        .item           (item),
        .counter_offset (offset_reg),
        .result         (res)
    );

    vgt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata = {6'd0, m_res.irq_pulse, m_res.access_error,
                           m_res.read_high, m_res.read_low};

endmodule
